FILE: rtl/core/rtbd_pkg.sv
`default_nettype none

package rtbd_pkg;

  // Coordinate and velocity width of the item fields
  localparam int COORD_WIDTH = 16;
  // Shared multiplier operand and product widths
  localparam int MUL_W  = 2 * COORD_WIDTH;
  localparam int PROD_W = 2 * MUL_W;
  // Region compare width: magnitude times 256 against a 16-bit limit shifted by up to 15
  localparam int ROI_W  = (COORD_WIDTH + 8 > 31) ? COORD_WIDTH + 8 : 31;

  localparam int LIMIT_W     = 16;
  localparam int THR_W       = 8;
  localparam int HOLD_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Command codes
  localparam logic [1:0] CMD_OBJECT    = 2'd0;
  localparam logic [1:0] CMD_FRAME_END = 2'd1;
  localparam logic [1:0] CMD_TICK      = 2'd2;

  // Object list kinds (other codes act as cluster objects)
  localparam logic [1:0] KIND_TRACKED  = 2'd0;
  localparam logic [1:0] KIND_DETECTED = 2'd1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROI_HALF_WIDTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FWD_LIMIT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_LIMIT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TTC_LIMIT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS     = 3'd4;

  // Register reset values
  localparam logic [LIMIT_W-1:0] RST_ROI_HALF_WIDTH = 16'd256;
  localparam logic [LIMIT_W-1:0] RST_FWD_LIMIT      = 16'd1280;
  localparam logic [LIMIT_W-1:0] RST_STOP_LIMIT     = 16'd1024;
  localparam logic [THR_W-1:0]   RST_TTC_LIMIT      = 8'd48;
  localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS     = 16'd500;

  typedef struct packed {
    logic [1:0]                    command;
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] x_pos;
    logic signed [COORD_WIDTH-1:0] y_pos;
    logic signed [COORD_WIDTH-1:0] vel_x;
    logic signed [COORD_WIDTH-1:0] vel_y;
    logic signed [COORD_WIDTH-1:0] doppler;
    logic [3:0]                    frac_bits;
    logic                          last_in_frame;
  } item_t;

  typedef struct packed {
    logic object_brake;
    logic frame_brake;
    logic combined_brake;
    logic frame_end;
  } result_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] roi_half_width;
    logic [LIMIT_W-1:0] fwd_limit;
    logic [LIMIT_W-1:0] stop_limit;
    logic [THR_W-1:0]   ttc_limit;
  } cfg_t;

  typedef struct packed {
    logic start;
  } obj_req_t;

  typedef struct packed {
    logic done;
    logic brake;
  } obj_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/rtbd_mul.sv
`default_nettype none

// Shared multiplier, product registered
module rtbd_mul (
  input  wire logic                         clk,
  input  wire logic [rtbd_pkg::MUL_W-1:0]   a,
  input  wire logic [rtbd_pkg::MUL_W-1:0]   b,
  output logic      [rtbd_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= rtbd_pkg::PROD_W'(a) * rtbd_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

FILE: rtl/core/rtbd_obj.sv
`default_nettype none

// Object decision sequencer around one shared multiplier
module rtbd_obj (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rtbd_pkg::item_t   item,
  input  wire rtbd_pkg::cfg_t    cfg,
  input  wire rtbd_pkg::obj_req_t req,
  output rtbd_pkg::obj_rsp_t     rsp
);

  localparam int C  = rtbd_pkg::COORD_WIDTH;
  localparam int MW = rtbd_pkg::MUL_W;
  localparam int PW = rtbd_pkg::PROD_W;
  localparam int RW = rtbd_pkg::ROI_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROI, ST_SQ_Y, ST_SUM_R, ST_TRK_P2, ST_TRK_PM,
    ST_DET_D2, ST_DET_MUL, ST_CMP
  } state_t;

  state_t         state;
  logic [MW-1:0]  acc;
  logic [MW-1:0]  r2;
  logic [PW-1:0]  lhs;
  logic [MW-1:0]  mul_a;
  logic [MW-1:0]  mul_b;
  logic [PW-1:0]  prod;

  logic [C-1:0]   xm, ym, vxm, vym, dm;
  logic           trk, det;
  logic           out_roi, stop_hit;
  logic [MW-1:0]  p1, p2, pm;
  logic           s1, s2, pneg;
  logic           step_done, step_brake;

  function automatic logic [C-1:0] mag_f(input logic [C-1:0] v);
    mag_f = v[C-1] ? ((~v) + C'(1)) : v;
  endfunction

  rtbd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign xm  = mag_f(item.x_pos);
  assign ym  = mag_f(item.y_pos);
  assign vxm = mag_f(item.vel_x);
  assign vym = mag_f(item.vel_y);
  assign dm  = mag_f(item.doppler);
  assign trk = (item.kind == rtbd_pkg::KIND_TRACKED);
  assign det = (item.kind == rtbd_pkg::KIND_DETECTED);

  // Region and immediate stop tests: magnitude * 256 against limit << frac_bits
  always_comb begin
    out_roi  = ((RW'(xm) << 8) > (RW'(cfg.roi_half_width) << item.frac_bits)) ||
               ((RW'(ym) << 8) > (RW'(cfg.fwd_limit) << item.frac_bits));
    stop_hit = ((RW'(ym) << 8) <= (RW'(cfg.stop_limit) << item.frac_bits));
  end

  // Signed sum of the two dot product terms, kept as sign and magnitude
  always_comb begin
    p1 = acc;
    p2 = prod[MW-1:0];
    s1 = (item.x_pos[C-1] != item.vel_x[C-1]) && (p1 != '0);
    s2 = (item.y_pos[C-1] != item.vel_y[C-1]) && (p2 != '0);
    if (s1 == s2) begin
      pm   = p1 + p2;
      pneg = s1;
    end else if (p1 >= p2) begin
      pm   = p1 - p2;
      pneg = s1;
    end else begin
      pm   = p2 - p1;
      pneg = s2;
    end
  end

  // Finish condition and decision of the current step
  always_comb begin
    step_done  = 1'b0;
    step_brake = 1'b0;
    unique case (state)
      ST_ROI: begin
        step_done  = out_roi || stop_hit || (!trk && !det);
        step_brake = !out_roi && stop_hit;
      end
      ST_SUM_R: begin
        step_done = !trk && (!item.doppler[C-1] || dm == '0);
      end
      ST_TRK_PM: begin
        step_done = !pneg || pm == '0;
      end
      ST_CMP: begin
        step_done  = 1'b1;
        step_brake = (lhs < prod);
      end
      default: begin
      end
    endcase
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_ROI: begin
        mul_a = MW'(xm);
        mul_b = MW'(xm);
      end
      ST_SQ_Y: begin
        mul_a = MW'(ym);
        mul_b = MW'(ym);
      end
      ST_SUM_R: begin
        if (trk) begin
          mul_a = MW'(xm);
          mul_b = MW'(vxm);
        end else begin
          mul_a = MW'(cfg.ttc_limit);
          mul_b = MW'(cfg.ttc_limit);
        end
      end
      ST_TRK_P2: begin
        mul_a = MW'(ym);
        mul_b = MW'(vym);
      end
      ST_TRK_PM: begin
        mul_a = MW'(cfg.ttc_limit);
        mul_b = pm;
      end
      ST_DET_D2: begin
        mul_a = MW'(dm);
        mul_b = MW'(dm);
      end
      ST_DET_MUL: begin
        mul_a = acc;
        mul_b = prod[MW-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.done  <= 1'b0;
      rsp.brake <= 1'b0;
    end else begin
      rsp.done <= step_done;
      if (step_done) begin
        rsp.brake <= step_brake;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_ROI;
          end
        end
        ST_ROI: begin
          state <= step_done ? ST_IDLE : ST_SQ_Y;
        end
        ST_SQ_Y: begin
          acc   <= prod[MW-1:0];
          state <= ST_SUM_R;
        end
        ST_SUM_R: begin
          r2 <= acc + prod[MW-1:0];
          if (step_done) begin
            state <= ST_IDLE;
          end else if (trk) begin
            state <= ST_TRK_P2;
          end else begin
            state <= ST_DET_D2;
          end
        end
        ST_TRK_P2: begin
          acc   <= prod[MW-1:0];
          state <= ST_TRK_PM;
        end
        ST_TRK_PM: begin
          if (step_done) begin
            state <= ST_IDLE;
          end else begin
            lhs   <= PW'(r2) << 4;
            state <= ST_CMP;
          end
        end
        ST_DET_D2: begin
          acc   <= prod[MW-1:0];
          state <= ST_DET_MUL;
        end
        ST_DET_MUL: begin
          lhs   <= PW'(r2) << 8;
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/radar_ttc_brake_decision_top.sv
`default_nettype none

// Radar emergency brake decision. Items arrive on the item channel: objects
// (framed by last_in_frame), empty frame ends and time ticks. Every object and
// every frame end yields one result on the result channel; ticks yield none.
// An object brakes when it lies inside the lateral and forward region and is
// either within the stop distance or approaching with a time to collision
// below the programmed time to collision limit; the time to collision test is
// done exactly on squared
// fixed-point terms by one shared 32x32 multiplier stepped by a small
// sequencer. Tracked frames set the tracked status to the OR of their
// objects; detected frames latch a hold that releases after hold_ticks ticks
// without a hit; cluster frames change no status. combined_brake on a closing
// result is detected hold OR tracked status. Throughput: one item at a time.
// A tick is handled while idle, an empty frame end goes straight to the post
// step, and an object ends at the region or stop test, when a detected or
// tracked object is found not approaching, or after the full time to collision
// compare (five multiplies through the shared unit plus the compare).
// A finished result sits in the output register while the next item is taken;
// the block only waits when a new result is ready and the old one is still
// stalled. Write configuration only while idle.
module radar_ttc_brake_decision_top #(
  parameter int TICK_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // item channel
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire rtbd_pkg::item_t                       item,
  // result channel
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output rtbd_pkg::result_t                          result,
  // configuration write port
  input  wire logic                                  cfg_write,
  input  wire logic [rtbd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [rtbd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Compare width for the tick counter against the 16-bit hold register
  localparam int CMP_W = (TICK_WIDTH > rtbd_pkg::HOLD_W) ? TICK_WIDTH : rtbd_pkg::HOLD_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_POST} state_t;

  state_t                          state;
  rtbd_pkg::item_t                 item_q;      // held item while it is worked on
  rtbd_pkg::cfg_t                  cfg;
  logic [rtbd_pkg::HOLD_W-1:0]     hold_ticks;
  rtbd_pkg::obj_req_t              obj_req;
  rtbd_pkg::obj_rsp_t              obj_rsp;
  logic                            obj_bit;     // object decision waiting for post

  // Decision state
  logic [TICK_WIDTH-1:0]           ticks_since_hit;
  logic                            detected_hold;
  logic                            tracked_status;
  logic                            frame_any_brake;

  // Post step results
  logic                            item_xfer;
  logic                            load;
  logic                            closing;
  logic                            fab;
  logic                            detected_hold_next;
  logic                            tracked_status_next;
  logic                            clear_ticks;
  logic [CMP_W-1:0]                ticks_ext;
  logic [CMP_W-1:0]                hold_ext;
  rtbd_pkg::result_t               res_next;

  rtbd_obj u_obj (
    .clk  (clk),
    .rst  (rst),
    .item (item_q),
    .cfg  (cfg),
    .req  (obj_req),
    .rsp  (obj_rsp)
  );

  // Take a new item only when no item is in flight
  assign item_stall = (state != S_IDLE);
  assign item_xfer  = item_valid && !item_stall;

  // Load the output register once it is free
  assign load = (state == S_POST) && (!result_valid || !result_stall);

  assign ticks_ext = CMP_W'(ticks_since_hit);
  assign hold_ext  = CMP_W'(hold_ticks);

  // Frame bookkeeping for the item at the post step
  always_comb begin
    closing             = (item_q.command == rtbd_pkg::CMD_FRAME_END) || item_q.last_in_frame;
    fab                 = frame_any_brake || obj_bit;
    detected_hold_next  = detected_hold;
    tracked_status_next = tracked_status;
    clear_ticks         = 1'b0;
    if (closing) begin
      if (item_q.kind == rtbd_pkg::KIND_TRACKED) begin
        tracked_status_next = fab;
      end else if (item_q.kind == rtbd_pkg::KIND_DETECTED) begin
        if (fab) begin
          clear_ticks        = 1'b1;
          detected_hold_next = 1'b1;
        end else if (ticks_ext >= hold_ext) begin
          detected_hold_next = 1'b0;
        end
      end
    end
    res_next.object_brake   = obj_bit;
    res_next.frame_brake    = closing && fab;
    res_next.combined_brake = closing && (detected_hold_next || tracked_status_next);
    res_next.frame_end      = closing;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_half_width <= rtbd_pkg::RST_ROI_HALF_WIDTH;
      cfg.fwd_limit      <= rtbd_pkg::RST_FWD_LIMIT;
      cfg.stop_limit     <= rtbd_pkg::RST_STOP_LIMIT;
      cfg.ttc_limit      <= rtbd_pkg::RST_TTC_LIMIT;
      hold_ticks         <= rtbd_pkg::RST_HOLD_TICKS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rtbd_pkg::REG_ROI_HALF_WIDTH: cfg.roi_half_width <= cfg_data;
        rtbd_pkg::REG_FWD_LIMIT:      cfg.fwd_limit      <= cfg_data;
        rtbd_pkg::REG_STOP_LIMIT:     cfg.stop_limit     <= cfg_data;
        rtbd_pkg::REG_TTC_LIMIT:      cfg.ttc_limit      <= cfg_data[rtbd_pkg::THR_W-1:0];
        rtbd_pkg::REG_HOLD_TICKS:     hold_ticks         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted item; payload needs no reset
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      item_q <= item;
    end
  end

  // Sequencer, decision state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      obj_req.start   <= 1'b0;
      obj_bit         <= 1'b0;
      ticks_since_hit <= '0;
      detected_hold   <= 1'b0;
      tracked_status  <= 1'b0;
      frame_any_brake <= 1'b0;
      result_valid    <= 1'b0;
      result          <= '0;
    end else begin
      // start the object sequencer on an object transfer
      obj_req.start <= item_xfer && (item.command == rtbd_pkg::CMD_OBJECT);
      // drop the result once the far side takes it and nothing new replaces it
      if (result_valid && !result_stall && !load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_xfer) begin
            unique case (item.command)
              rtbd_pkg::CMD_OBJECT: begin
                state <= S_RUN;
              end
              rtbd_pkg::CMD_FRAME_END: begin
                obj_bit <= 1'b0;
                state   <= S_POST;
              end
              rtbd_pkg::CMD_TICK: begin
                // advance, saturating at hold_ticks or the counter maximum
                if (ticks_ext < hold_ext && !(&ticks_since_hit)) begin
                  ticks_since_hit <= ticks_since_hit + TICK_WIDTH'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RUN: begin
          if (obj_rsp.done) begin
            obj_bit <= obj_rsp.brake;
            state   <= S_POST;
          end
        end
        S_POST: begin
          if (load) begin
            result          <= res_next;
            result_valid    <= 1'b1;
            frame_any_brake <= closing ? 1'b0 : fab;
            detected_hold   <= detected_hold_next;
            tracked_status  <= tracked_status_next;
            if (clear_ticks) begin
              ticks_since_hit <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The object sequencer only finishes while the top waits for it
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    obj_rsp.done |-> (state == S_RUN))
    else $error("object decision finished outside run");

  // A tick never produces a result
  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && item.command == rtbd_pkg::CMD_TICK && !result_valid) |=> !result_valid)
    else $error("tick produced a result");

  // A closing result clears the frame accumulator
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (load && res_next.frame_end) |=> !frame_any_brake)
    else $error("frame accumulator not cleared at frame end");
`endif

endmodule

`default_nettype wire
